// ===== src/rgb_or_cmy_to_hsv_converter_unit_assert.svh =====
// assertion macros shared by the converter rtl
`ifndef RGB_OR_CMY_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_OR_CMY_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTH

// property holds at every clock edge outside reset
`define RCTH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rcth: assertion failed");

// antecedent implies consequent in the same cycle
`define RCTH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rcth: implication failed");

// antecedent implies consequent in the next cycle
`define RCTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rcth: next-cycle implication failed");

`else

`define RCTH_ASSERT(lbl, clk, rstn, prop)
`define RCTH_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RCTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/rcth_pkg.sv =====
`timescale 1ns / 1ps

package rcth_pkg;

  localparam int CompW   = 8;
  localparam int HueW    = 9;
  localparam int SatW    = 8;
  localparam int DenW    = 9;
  // 2*num + d, num < 360*d, d <= 255
  localparam int HueNumW = 18;
  // 510*d + max
  localparam int SatNumW = 17;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [HueW-1:0] HueWrap = 9'd360;

  typedef enum logic {
    CmdRgb = 1'b0,
    CmdCmy = 1'b1
  } cmd_e;

  // one classified pixel waiting for the dividers
  typedef struct packed {
    logic [HueNumW-1:0] hue_num;
    logic [DenW-1:0]    hue_den;
    logic [SatNumW-1:0] sat_num;
    logic [DenW-1:0]    sat_den;
    logic               hue_zero;
    logic               sat_zero;
    logic [CompW-1:0]   value;
    logic [CompW-1:0]   other_a;
    logic [CompW-1:0]   other_b;
    logic [CompW-1:0]   other_c;
  } rcth_work_t;

endpackage

// ===== src/rgb_or_cmy_to_hsv_converter_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// pixel     in         push / full        cmd_i, comp_a_i, comp_b_i, comp_c_i
// result    out        empty / pop        hue_o, saturation_o, value_o, other_a_o..other_c_o
//
// one pixel per clock sustained while the result side does not stall; from push to result
// a pixel passes the classify register and the queue, then nine restoring-division
// stages shared by hue and saturation
// a four-entry queue sits between classify and divide; each side stalls on its own
// a stalled result holds the whole divider pipeline; the queue and classify stage absorb it
// reset clears the valid flags, the queue count and the queue pointers only, no clearing pass

module rgb_or_cmy_to_hsv_converter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       cmd_i,
  input  logic [rcth_pkg::CompW-1:0] comp_a_i,
  input  logic [rcth_pkg::CompW-1:0] comp_b_i,
  input  logic [rcth_pkg::CompW-1:0] comp_c_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [rcth_pkg::HueW-1:0]  hue_o,
  output logic [rcth_pkg::SatW-1:0]  saturation_o,
  output logic [rcth_pkg::CompW-1:0] value_o,
  output logic [rcth_pkg::CompW-1:0] other_a_o,
  output logic [rcth_pkg::CompW-1:0] other_b_o,
  output logic [rcth_pkg::CompW-1:0] other_c_o
);
  import rcth_pkg::*;

  logic       q_push, q_full, q_pop, q_empty;
  rcth_work_t q_in, q_head;

  rcth_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .cmd_i    (cmd_i),
    .comp_a_i (comp_a_i),
    .comp_b_i (comp_b_i),
    .comp_c_i (comp_c_i),
    .q_push_o (q_push),
    .q_work_o (q_in),
    .q_full_i (q_full)
  );

  rcth_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  rcth_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o),
    .other_a_o    (other_a_o),
    .other_b_o    (other_b_o),
    .other_c_o    (other_c_o)
  );

endmodule

// ===== src/rcth_front.sv =====
`timescale 1ns / 1ps

module rcth_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic                     cmd_i,
  input  logic [rcth_pkg::CompW-1:0] comp_a_i,
  input  logic [rcth_pkg::CompW-1:0] comp_b_i,
  input  logic [rcth_pkg::CompW-1:0] comp_c_i,
  output logic                     q_push_o,
  output rcth_pkg::rcth_work_t     q_work_o,
  input  logic                     q_full_i
);
  import rcth_pkg::*;

  logic             f_valid_q, f_valid_d;
  rcth_work_t       f_work_q, f_work_d;
  logic             accept;
  logic [CompW-1:0] r, g, b, mx, mn, d;
  logic signed [19:0] rs, gs, bs, ds, num;

  assign full     = f_valid_q && q_full_i;
  assign accept   = push && !full;
  assign q_push_o = f_valid_q && !q_full_i;
  assign q_work_o = f_work_q;

  always_comb begin
    if (cmd_e'(cmd_i) == CmdCmy) begin
      r = ~comp_a_i;
      g = ~comp_b_i;
      b = ~comp_c_i;
    end else begin
      r = comp_a_i;
      g = comp_b_i;
      b = comp_c_i;
    end

    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;

    rs = signed'(20'(r));
    gs = signed'(20'(g));
    bs = signed'(20'(b));
    ds = signed'(20'(d));

    // sextant of the largest component, red wins ties over green over blue
    if (r == mx) begin
      num = 20'sd60 * (gs - bs);
      if (num < 0) num = num + 20'sd360 * ds;
    end else if (g == mx) begin
      num = 20'sd120 * ds + 20'sd60 * (bs - rs);
    end else begin
      num = 20'sd240 * ds + 20'sd60 * (rs - gs);
    end

    f_work_d.hue_num  = {num[HueNumW-2:0], 1'b0} + HueNumW'(d);
    f_work_d.hue_den  = {d, 1'b0};
    f_work_d.sat_num  = SatNumW'(d) * SatNumW'(510) + SatNumW'(mx);
    f_work_d.sat_den  = {mx, 1'b0};
    f_work_d.hue_zero = (d == '0);
    f_work_d.sat_zero = (mx == '0);
    f_work_d.value    = mx;
    f_work_d.other_a  = ~comp_a_i;
    f_work_d.other_b  = ~comp_b_i;
    f_work_d.other_c  = ~comp_c_i;
  end

  assign f_valid_d = accept || (f_valid_q && q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_work_q <= f_work_d;
    end
  end

endmodule

// ===== src/rcth_fifo.sv =====
`timescale 1ns / 1ps
`include "rgb_or_cmy_to_hsv_converter_unit_assert.svh"

module rcth_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rcth_pkg::rcth_work_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output rcth_pkg::rcth_work_t data_o,
  output logic                 empty_o
);
  import rcth_pkg::*;

  rcth_work_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `RCTH_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= QueueCntW'(QueueDepth))
  `RCTH_ASSERT_NEXT(a_cnt_inc, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)
  `RCTH_ASSERT_NEXT(a_cnt_dec, clk_i, rst_ni, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1)

endmodule

// ===== src/rcth_back.sv =====
`timescale 1ns / 1ps
`include "rgb_or_cmy_to_hsv_converter_unit_assert.svh"

module rcth_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  rcth_pkg::rcth_work_t       q_head_i,
  output logic                       q_pop_o,
  output logic                       empty,
  input  logic                       pop,
  output logic [rcth_pkg::HueW-1:0]  hue_o,
  output logic [rcth_pkg::SatW-1:0]  saturation_o,
  output logic [rcth_pkg::CompW-1:0] value_o,
  output logic [rcth_pkg::CompW-1:0] other_a_o,
  output logic [rcth_pkg::CompW-1:0] other_b_o,
  output logic [rcth_pkg::CompW-1:0] other_c_o
);
  import rcth_pkg::*;

  typedef struct packed {
    rcth_work_t      work;
    logic [HueW-1:0] hue_q;
    logic [SatW-1:0] sat_q;
  } stage_t;

  localparam int NumStages = HueW;

  stage_t pipe_q  [NumStages];
  stage_t stage_d [NumStages];
  logic [NumStages-1:0] valid_q;
  logic advance;

  // single enable for the whole divider pipeline
  assign advance = !valid_q[NumStages-1] || pop;
  assign q_pop_o = advance && !q_empty_i;
  assign empty   = !valid_q[NumStages-1];

  // restoring division, one quotient bit of hue and of saturation per stage, msb first
  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam int Hb = NumStages - 1 - s;
    stage_t             cur;
    logic [HueNumW-1:0] hue_div;
    logic [SatNumW-1:0] sat_div;
    logic               hue_bit, sat_bit;

    if (s == 0) begin : g_first
      assign cur = '{work: q_head_i, hue_q: '0, sat_q: '0};
    end else begin : g_next
      assign cur = pipe_q[s-1];
    end

    assign hue_div = HueNumW'(cur.work.hue_den) << Hb;
    assign sat_div = SatNumW'(cur.work.sat_den) << Hb;
    assign hue_bit = (cur.work.hue_num >= hue_div);
    assign sat_bit = (cur.work.sat_num >= sat_div);

    always_comb begin
      stage_d[s] = cur;
      if (hue_bit) stage_d[s].work.hue_num = cur.work.hue_num - hue_div;
      if (sat_bit) stage_d[s].work.sat_num = cur.work.sat_num - sat_div;
      stage_d[s].hue_q = {cur.hue_q[HueW-2:0], hue_bit};
      // saturation never exceeds 255, so its top bit falls off harmlessly
      stage_d[s].sat_q = {cur.sat_q[SatW-2:0], sat_bit};
      if (s == NumStages - 1) begin
        if (stage_d[s].hue_q >= HueWrap) stage_d[s].hue_q = stage_d[s].hue_q - HueWrap;
        if (cur.work.hue_zero) stage_d[s].hue_q = '0;
        if (cur.work.sat_zero) stage_d[s].sat_q = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[NumStages-2:0], !q_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < NumStages; i++) begin
        pipe_q[i] <= stage_d[i];
      end
    end
  end

  assign hue_o        = pipe_q[NumStages-1].hue_q;
  assign saturation_o = pipe_q[NumStages-1].sat_q;
  assign value_o      = pipe_q[NumStages-1].work.value;
  assign other_a_o    = pipe_q[NumStages-1].work.other_a;
  assign other_b_o    = pipe_q[NumStages-1].work.other_b;
  assign other_c_o    = pipe_q[NumStages-1].work.other_c;

  `RCTH_ASSERT_IMPL(a_hue_range, clk_i, rst_ni, !empty, hue_o < HueWrap)
  `RCTH_ASSERT_IMPL(a_black_sat, clk_i, rst_ni, !empty && value_o == '0, saturation_o == '0)
  `RCTH_ASSERT_IMPL(a_black_hue, clk_i, rst_ni, !empty && value_o == '0, hue_o == '0)

endmodule
